/* hdl/ptw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ptw_pkg;

  localparam int TablePages      = 16;
  localparam int EntriesPerTable = 512;
  localparam int StoreDepth      = TablePages * EntriesPerTable;

  localparam int PAGE_W  = $clog2(TablePages);
  localparam int NFP_W   = $clog2(TablePages + 1);
  localparam int IDX_W   = $clog2(EntriesPerTable);
  localparam int SADDR_W = PAGE_W + IDX_W;
  localparam int PFN_W   = 40;
  localparam int LEVEL_W = 2;

  localparam logic [LEVEL_W-1:0] LAST_LEVEL = 2'd3;

  // request codes
  localparam logic [1:0] MODE_MAP    = 2'd0;
  localparam logic [1:0] MODE_UNMAP  = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // present + writable for a freshly made table entry
  localparam logic [11:0] NEW_TABLE_FLAGS = 12'h003;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL
  } state_t;

  typedef struct packed {
    logic       clr_step;   // write zero at sweep address, advance
    logic       load;       // capture request, restart at root
    logic       rd;         // read entry for the current level
    logic       descend;    // move to next level
    logic       alloc;      // write new table pointer, bump free page
    logic       wr_leaf;    // write leaf entry
    logic       res_load;   // load output register
    logic [1:0] res_status;
    logic       res_xlat;
    logic       res_inval;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic [1:0] mode;
    logic       last_level;
    logic       present;
    logic       ptr_ok;
    logic       full;
    logic       out_busy;
  } stat_t;

endpackage

`default_nettype wire

/* hdl/ptw_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module ptw_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire ptw_pkg::stat_t stat,
  output ptw_pkg::cmd_t      cmd
);

  ptw_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptw_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.res_status = ptw_pkg::ST_OK;
    in_stall       = (state != ptw_pkg::S_IDLE);

    unique case (state)
      ptw_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = ptw_pkg::S_IDLE;
        end
      end

      ptw_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ptw_pkg::S_READ;
        end
      end

      ptw_pkg::S_READ: begin
        cmd.rd     = 1'b1;
        state_next = ptw_pkg::S_EVAL;
      end

      ptw_pkg::S_EVAL: begin
        if (stat.mode != ptw_pkg::MODE_MAP && stat.mode != ptw_pkg::MODE_UNMAP &&
            stat.mode != ptw_pkg::MODE_LOOKUP) begin
          // unused code: no effect, all-zero word
          if (!stat.out_busy) begin
            cmd.res_load = 1'b1;
            state_next   = ptw_pkg::S_IDLE;
          end
        end else if (!stat.last_level) begin
          if (stat.present) begin
            if (stat.ptr_ok) begin
              cmd.descend = 1'b1;
              state_next  = ptw_pkg::S_READ;
            end else if (!stat.out_busy) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ptw_pkg::ST_MISSING;
              state_next     = ptw_pkg::S_IDLE;
            end
          end else if (stat.mode != ptw_pkg::MODE_MAP) begin
            if (!stat.out_busy) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ptw_pkg::ST_MISSING;
              state_next     = ptw_pkg::S_IDLE;
            end
          end else if (stat.full) begin
            if (!stat.out_busy) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ptw_pkg::ST_FULL;
              state_next     = ptw_pkg::S_IDLE;
            end
          end else begin
            cmd.alloc   = 1'b1;
            cmd.descend = 1'b1;
            state_next  = ptw_pkg::S_READ;
          end
        end else if (!stat.out_busy) begin
          // leaf level: hold until the output register is free
          cmd.res_load = 1'b1;
          state_next   = ptw_pkg::S_IDLE;
          unique case (stat.mode)
            ptw_pkg::MODE_MAP:   cmd.wr_leaf = 1'b1;
            ptw_pkg::MODE_UNMAP: begin
              cmd.wr_leaf   = 1'b1;
              cmd.res_inval = 1'b1;
            end
            default:             cmd.res_xlat = 1'b1;
          endcase
        end
      end

      default: state_next = ptw_pkg::S_CLEAR;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/ptw_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module ptw_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ptw_pkg::cmd_t cmd,
  output ptw_pkg::stat_t     stat,
  input  wire logic          table_base_wr_en,
  input  wire logic [51:0]   table_base,
  input  wire logic [1:0]    mode,
  input  wire logic [47:0]   virtual_address,
  input  wire logic [51:0]   physical_address,
  input  wire logic [63:0]   page_flags,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [63:0]        translated_address,
  output logic [1:0]         status,
  output logic               invalidate
);

  logic [63:0] store [ptw_pkg::StoreDepth];

  logic [51:0]                  base;
  logic [ptw_pkg::NFP_W-1:0]    nfp;
  logic [ptw_pkg::SADDR_W-1:0]  clr_addr;
  logic [ptw_pkg::LEVEL_W-1:0]  level;
  logic [ptw_pkg::PAGE_W-1:0]   page;
  logic [1:0]                   req_mode;
  logic [47:0]                  req_va;
  logic [51:0]                  req_pa;
  logic [63:0]                  req_flags;
  logic [63:0]                  rd_data;

  logic [ptw_pkg::IDX_W-1:0]    idx;
  logic [ptw_pkg::SADDR_W-1:0]  addr;
  logic [ptw_pkg::PFN_W:0]      diff;
  logic [ptw_pkg::PFN_W-1:0]    new_pfn;
  logic                         mem_we;
  logic [ptw_pkg::SADDR_W-1:0]  mem_waddr;
  logic [63:0]                  mem_wdata;

  always_comb begin
    unique case (level)
      2'd0:    idx = req_va[47:39];
      2'd1:    idx = req_va[38:30];
      2'd2:    idx = req_va[29:21];
      default: idx = req_va[20:12];
    endcase
  end

  assign addr = {page, idx};

  // pointer decode in page units; a borrow means far out of range
  assign diff    = {1'b0, rd_data[51:12]} - {1'b0, base[51:12]};
  assign new_pfn = base[51:12] + ptw_pkg::PFN_W'(nfp);

  always_comb begin
    mem_we    = cmd.clr_step | cmd.alloc | cmd.wr_leaf;
    mem_waddr = cmd.clr_step ? clr_addr : addr;
    if (cmd.alloc) begin
      mem_wdata = {12'h000, new_pfn, ptw_pkg::NEW_TABLE_FLAGS};
    end else if (cmd.wr_leaf && req_mode == ptw_pkg::MODE_MAP) begin
      mem_wdata = {12'h000, req_pa} | req_flags;
    end else begin
      mem_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd) begin
      rd_data <= store[addr];
    end
  end

  always_comb begin
    stat.clr_last   = (clr_addr == ptw_pkg::SADDR_W'(ptw_pkg::StoreDepth - 1));
    stat.mode       = req_mode;
    stat.last_level = (level == ptw_pkg::LAST_LEVEL);
    stat.present    = rd_data[0];
    stat.ptr_ok     = !diff[ptw_pkg::PFN_W] && (diff[ptw_pkg::PFN_W-1:ptw_pkg::NFP_W] == '0)
                      && (diff[ptw_pkg::NFP_W-1:0] < nfp);
    stat.full       = (nfp == ptw_pkg::NFP_W'(ptw_pkg::TablePages));
    stat.out_busy   = out_valid & out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base      <= '0;
      nfp       <= ptw_pkg::NFP_W'(1);
      clr_addr  <= '0;
      level     <= '0;
      page      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (table_base_wr_en) begin
        base <= table_base;
      end
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.load) begin
        level <= '0;
        page  <= '0;
      end else if (cmd.descend) begin
        level <= level + 1'b1;
        page  <= cmd.alloc ? nfp[ptw_pkg::PAGE_W-1:0] : diff[ptw_pkg::PAGE_W-1:0];
      end
      if (cmd.alloc) begin
        nfp <= nfp + 1'b1;
      end
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode  <= mode;
      req_va    <= virtual_address;
      req_pa    <= physical_address;
      req_flags <= page_flags;
    end
    if (cmd.res_load) begin
      translated_address <= cmd.res_xlat ? {rd_data[63:12], 12'h000} : '0;
      status             <= cmd.res_status;
      invalidate         <= cmd.res_inval;
    end
  end

endmodule

`default_nettype wire

/* hdl/four_level_page_table_walker.sv */
// Walk: each of the four levels goes through a registered store read (S_READ), then a
// decode/write step (S_EVAL); the result word waits while the output register is busy.
// No new request is taken until a walk is done and the walker is idle again; a walk
// may also stop early at level n (0..2) with a missing or full status.
// Reset: synchronous; afterwards a clearing pass zeroes the 8192-entry table store,
// one entry a cycle, and no request is taken until it ends.
`timescale 1ns / 1ps
`default_nettype none

module four_level_page_table_walker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        table_base_wr_en,
  input  wire logic [51:0] table_base,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  mode,
  input  wire logic [47:0] virtual_address,
  input  wire logic [51:0] physical_address,
  input  wire logic [63:0] page_flags,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      translated_address,
  output logic [1:0]       status,
  output logic             invalidate
);

  ptw_pkg::cmd_t  cmd;
  ptw_pkg::stat_t stat;

  ptw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ptw_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .table_base_wr_en   (table_base_wr_en),
    .table_base         (table_base),
    .mode               (mode),
    .virtual_address    (virtual_address),
    .physical_address   (physical_address),
    .page_flags         (page_flags),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .translated_address (translated_address),
    .status             (status),
    .invalidate         (invalidate)
  );

endmodule

`default_nettype wire

/* bench/four_level_page_table_walker_test.sv */
`timescale 1ns / 1ps

module four_level_page_table_walker_test;

  localparam logic [1:0]  MODE_SPARE  = 2'd3;          // unused request code
  localparam logic [63:0] PfnMask     = 64'h000F_FFFF_FFFF_F000;
  localparam logic [51:0] PaTop       = 52'hF_FFFF_FFFF_F000;
  localparam logic [47:0] VaTop       = 48'hFFFF_FFFF_FFFF;
  localparam logic [63:0] FlagsAll    = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int          DirectedLen = 24;
  localparam int          PhaseItems  = 315;
  localparam int          QuietLimit  = 30000;       // covers the store sweep after reset

  typedef struct packed {
    logic [1:0]  op;
    logic [47:0] va;
    logic [51:0] pa;
    logic [63:0] flags;
  } walk_req_t;

  typedef struct packed {
    logic [63:0] xlat;
    logic [1:0]  st;
    logic        inval;
  } walk_res_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [47:0] va;
    logic [51:0] pa;
    logic [63:0] flags;
    logic        known;
    logic [63:0] xlat;
    logic [1:0]  st;
    logic        inval;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        table_base_wr_en;
  logic [51:0] table_base;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  mode;
  logic [47:0] virtual_address;
  logic [51:0] physical_address;
  logic [63:0] page_flags;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] translated_address;
  logic [1:0]  status;
  logic        invalidate;

  four_level_page_table_walker dut (
    .clk                (clk),
    .rst                (rst),
    .table_base_wr_en   (table_base_wr_en),
    .table_base         (table_base),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .mode               (mode),
    .virtual_address    (virtual_address),
    .physical_address   (physical_address),
    .page_flags         (page_flags),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .translated_address (translated_address),
    .status             (status),
    .invalidate         (invalidate)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the table store and walker state
  logic [63:0] pt_mem [0:ptw_pkg::StoreDepth-1];
  int unsigned free_page;
  logic [51:0] base_reg;

  walk_res_t awaited_translations [$];
  dir_row_t  directed_rows [DirectedLen];
  int        mismatches = 0;
  int        burst_left = 0;
  int        quiet_cycles = 0;
  logic [6:0] stall_clock = '0;
  int        stall_style = 0;

  function automatic logic [47:0] va_of(input int l4, input int l3, input int l2,
                                        input int l1, input int off);
    logic [31:0] a, b, c, d, e;
    a = l4; b = l3; c = l2; d = l1; e = off;
    return {a[8:0], b[8:0], c[8:0], d[8:0], e[11:0]};
  endfunction

  // upper three levels; allocates missing tables when grow is set
  function automatic logic [1:0] walk_tables(input logic [47:0] va, input logic grow,
                                             output int unsigned leaf);
    int unsigned pg;
    int unsigned slot;
    int          lvl;
    logic [63:0] ent;
    logic [63:0] off;
    logic [63:0] base_a;
    pg = 0;
    base_a = {12'h0, base_reg[51:12], 12'h0};
    for (lvl = 0; lvl < 3; lvl++) begin
      slot = pg * ptw_pkg::EntriesPerTable + int'(va[39 - 9 * lvl +: 9]);
      ent = pt_mem[slot];
      if (ent[0]) begin
        off = (ent & PfnMask) - base_a;
        if ((off >> 12) >= free_page || (off >> 12) >= ptw_pkg::TablePages)
          return ptw_pkg::ST_MISSING;
        pg = int'(off >> 12);
      end else if (!grow) begin
        return ptw_pkg::ST_MISSING;
      end else begin
        if (free_page >= ptw_pkg::TablePages) return ptw_pkg::ST_FULL;
        pt_mem[slot] = ((base_a + (64'(free_page) << 12)) & PfnMask) |
                       64'(ptw_pkg::NEW_TABLE_FLAGS);
        pg = free_page;
        free_page++;
      end
    end
    leaf = pg;
    return ptw_pkg::ST_OK;
  endfunction

  function automatic walk_res_t apply_request(input walk_req_t rq);
    walk_res_t   res;
    int unsigned leaf;
    res = '0;
    case (rq.op)
      ptw_pkg::MODE_MAP: begin
        res.st = walk_tables(rq.va, 1'b1, leaf);
        if (res.st == ptw_pkg::ST_OK)
          pt_mem[leaf * ptw_pkg::EntriesPerTable + int'(rq.va[20:12])] =
            {12'h0, rq.pa} | rq.flags;
      end
      ptw_pkg::MODE_UNMAP: begin
        res.st = walk_tables(rq.va, 1'b0, leaf);
        if (res.st == ptw_pkg::ST_OK) begin
          pt_mem[leaf * ptw_pkg::EntriesPerTable + int'(rq.va[20:12])] = '0;
          res.inval = 1'b1;
        end
      end
      ptw_pkg::MODE_LOOKUP: begin
        res.st = walk_tables(rq.va, 1'b0, leaf);
        if (res.st == ptw_pkg::ST_OK)
          res.xlat = pt_mem[leaf * ptw_pkg::EntriesPerTable + int'(rq.va[20:12])] &
                     ~64'hFFF;
      end
      default: ;
    endcase
    return res;
  endfunction

  // mostly indexes that hit tables already built, now and then any index
  function automatic int table_index();
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 511);
    case ($urandom_range(0, 6))
      0: return 0;
      1: return 1;
      2: return 2;
      3: return 3;
      4: return 6;
      5: return 7;
      default: return 511;
    endcase
  endfunction

  function automatic walk_req_t random_request();
    walk_req_t   rq;
    int          pick;
    logic [63:0] w;
    pick = $urandom_range(0, 99);
    rq.op = (pick < 30) ? ptw_pkg::MODE_MAP : (pick < 62) ? ptw_pkg::MODE_LOOKUP :
            (pick < 94) ? ptw_pkg::MODE_UNMAP : MODE_SPARE;
    rq.va = va_of(table_index(), table_index(), table_index(), table_index(),
                  $urandom_range(0, 4095));
    w = {$urandom, $urandom};
    rq.pa = {w[51:12], 12'h000};
    rq.flags = ($urandom_range(0, 3) == 0) ? 64'h0 : {$urandom, $urandom};
    return rq;
  endfunction

  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_word(input walk_req_t rq, input logic known, input walk_res_t fixed);
    walk_res_t got;
    in_valid         <= 1'b1;
    mode             <= rq.op;
    virtual_address  <= rq.va;
    physical_address <= rq.pa;
    page_flags       <= rq.flags;
    do @(posedge clk); while (in_stall !== 1'b0);
    got = apply_request(rq);
    awaited_translations.push_back(known ? fixed : got);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_translations.size() != 0);
  endtask

  task automatic load_base(input logic [51:0] v);
    drain_results();
    table_base_wr_en <= 1'b1;
    table_base       <= v;
    @(posedge clk);
    table_base_wr_en <= 1'b0;
    base_reg = v;
  endtask

  always @(posedge clk) begin
    stall_clock <= stall_clock + 1'b1;
    if (stall_clock == '0) stall_style <= $urandom_range(0, 3);
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_clock[3:0] < 4'd5);
    endcase
  end

  always @(posedge clk) begin
    walk_res_t e;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (awaited_translations.size() == 0) begin
        $error("unexpected result word: translated_address %h status %0d invalidate %0d",
               translated_address, status, invalidate);
        mismatches++;
      end else begin
        e = awaited_translations.pop_front();
        if (translated_address !== e.xlat) begin
          $error("translated_address: expected %h, got %h", e.xlat, translated_address);
          mismatches++;
        end
        if (status !== e.st) begin
          $error("status: expected %0d, got %0d", e.st, status);
          mismatches++;
        end
        if (invalidate !== e.inval) begin
          $error("invalidate: expected %0d, got %0d", e.inval, invalidate);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QuietLimit) begin
      $display("four_level_page_table_walker_test NOT OK");
      $finish;
    end
  end

  initial begin
    int          k;
    int          ph;
    logic [63:0] w;
    logic [51:0] phase_bases [6];
    walk_res_t   fixed;

    rst              = 1'b1;
    table_base_wr_en = 1'b0;
    table_base       = '0;
    in_valid         = 1'b0;
    mode             = ptw_pkg::MODE_MAP;
    virtual_address  = '0;
    physical_address = '0;
    page_flags       = '0;
    for (k = 0; k < ptw_pkg::StoreDepth; k++) pt_mem[k] = '0;
    free_page = 1;
    base_reg  = '0;

    // build the store up to full, then probe full and missing-table cases
    directed_rows = '{
      '{ptw_pkg::MODE_LOOKUP, va_of(0, 0, 0, 0, 0), 52'h0, 64'h0,
        1'b1, 64'h0, ptw_pkg::ST_MISSING, 1'b0},
      '{ptw_pkg::MODE_UNMAP,  va_of(0, 0, 0, 0, 0), 52'h0, 64'h0,
        1'b1, 64'h0, ptw_pkg::ST_MISSING, 1'b0},
      '{MODE_SPARE,           VaTop, PaTop, FlagsAll,
        1'b1, 64'h0, ptw_pkg::ST_OK, 1'b0},
      '{ptw_pkg::MODE_MAP,    va_of(0, 0, 0, 0, 0), PaTop, 64'h0,
        1'b1, 64'h0, ptw_pkg::ST_OK, 1'b0},
      '{ptw_pkg::MODE_LOOKUP, va_of(0, 0, 0, 0, 0), 52'h0, 64'h0,
        1'b1, {12'h0, PaTop}, ptw_pkg::ST_OK, 1'b0},
      '{ptw_pkg::MODE_MAP,    VaTop, 52'h0, FlagsAll,
        1'b1, 64'h0, ptw_pkg::ST_OK, 1'b0},
      '{ptw_pkg::MODE_LOOKUP, VaTop, 52'h0, 64'h0,
        1'b1, 64'hFFFF_FFFF_FFFF_F000, ptw_pkg::ST_OK, 1'b0},
      '{ptw_pkg::MODE_UNMAP,  VaTop, 52'h0, 64'h0,
        1'b1, 64'h0, ptw_pkg::ST_OK, 1'b1},
      '{ptw_pkg::MODE_UNMAP,  VaTop, 52'h0, 64'h0,
        1'b1, 64'h0, ptw_pkg::ST_OK, 1'b1},
      '{ptw_pkg::MODE_LOOKUP, VaTop, 52'h0, 64'h0,
        1'b1, 64'h0, ptw_pkg::ST_OK, 1'b0},
      '{ptw_pkg::MODE_MAP,    va_of(0, 0, 0, 5, 'h123), 52'h1_2345_6789_A000,
        64'h8000_0000_0000_0ABD, 1'b0, 64'h0, ptw_pkg::ST_OK, 1'b0},
      '{ptw_pkg::MODE_LOOKUP, va_of(0, 0, 0, 5, 0), 52'h0, 64'h0,
        1'b0, 64'h0, ptw_pkg::ST_OK, 1'b0},
      '{ptw_pkg::MODE_LOOKUP, va_of(0, 0, 1, 0, 0), 52'h0, 64'h0,
        1'b1, 64'h0, ptw_pkg::ST_MISSING, 1'b0},
      '{ptw_pkg::MODE_MAP,    va_of(1, 0, 0, 0, 0), 52'h7000, 64'h7,
        1'b0, 64'h0, ptw_pkg::ST_OK, 1'b0},
      '{ptw_pkg::MODE_MAP,    va_of(2, 7, 3, 9, 'hfff), 52'h8_0000_0000_0000, 64'h0,
        1'b0, 64'h0, ptw_pkg::ST_OK, 1'b0},
      '{ptw_pkg::MODE_MAP,    va_of(0, 0, 6, 0, 0), 52'h4_2000, 64'h1,
        1'b0, 64'h0, ptw_pkg::ST_OK, 1'b0},
      '{ptw_pkg::MODE_MAP,    va_of(3, 0, 0, 0, 0), 52'h9000, 64'h3,
        1'b1, 64'h0, ptw_pkg::ST_FULL, 1'b0},
      '{ptw_pkg::MODE_LOOKUP, va_of(3, 0, 0, 0, 0), 52'h0, 64'h0,
        1'b1, 64'h0, ptw_pkg::ST_MISSING, 1'b0},
      '{ptw_pkg::MODE_MAP,    va_of(3, 0, 0, 0, 0), 52'h9000, 64'h3,
        1'b1, 64'h0, ptw_pkg::ST_FULL, 1'b0},
      '{ptw_pkg::MODE_MAP,    va_of(4, 4, 4, 4, 0), 52'hA000, 64'h3,
        1'b1, 64'h0, ptw_pkg::ST_FULL, 1'b0},
      '{ptw_pkg::MODE_MAP,    va_of(0, 0, 6, 1, 0), 52'hA_BCDE_F012_3000, 64'h3,
        1'b0, 64'h0, ptw_pkg::ST_OK, 1'b0},
      '{ptw_pkg::MODE_LOOKUP, va_of(0, 0, 6, 1, 'hfff), 52'h0, 64'h0,
        1'b0, 64'h0, ptw_pkg::ST_OK, 1'b0},
      '{ptw_pkg::MODE_UNMAP,  va_of(0, 1, 0, 0, 0), 52'h0, 64'h0,
        1'b1, 64'h0, ptw_pkg::ST_MISSING, 1'b0},
      '{ptw_pkg::MODE_LOOKUP, va_of(2, 7, 3, 9, 0), 52'h0, 64'h0,
        1'b0, 64'h0, ptw_pkg::ST_OK, 1'b0}
    };

    w = {$urandom, $urandom};
    phase_bases[0] = 52'h0;
    phase_bases[1] = 52'h1000;        // pointers decode one page low
    phase_bases[2] = PaTop;           // every pointer stale
    phase_bases[3] = {w[51:12], 12'h000};
    phase_bases[4] = 52'h3000;
    phase_bases[5] = 52'h0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < DirectedLen; k++) begin
      pace_sender();
      fixed = '{directed_rows[k].xlat, directed_rows[k].st, directed_rows[k].inval};
      send_word('{directed_rows[k].op, directed_rows[k].va, directed_rows[k].pa,
                  directed_rows[k].flags}, directed_rows[k].known, fixed);
    end

    for (ph = 0; ph < 6; ph++) begin
      load_base(phase_bases[ph]);
      for (k = 0; k < PhaseItems; k++) begin
        if ($urandom_range(0, 199) == 0) drain_results();
        pace_sender();
        send_word(random_request(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (24) @(posedge clk);
    if (mismatches == 0)
      $display("four_level_page_table_walker_test OK");
    else
      $display("four_level_page_table_walker_test NOT OK");
    $finish;
  end

endmodule
